@@ rtl/wprwl_pkg.sv @@
`default_nettype none
package wprwl_pkg;

	localparam int OP_W = 3;
	localparam int ID_W = 4;
	localparam int ST_W = 3;

	localparam int TASK_COUNT_DEF   = 16;
	localparam int WAIT_DEPTH_DEF   = 16;
	localparam int READER_LIMIT_DEF = 255;

	typedef enum logic [OP_W-1:0] {
		OP_RD_LOCK   = 3'd0,
		OP_WR_LOCK   = 3'd1,
		OP_RD_UNLOCK = 3'd2,
		OP_WR_UNLOCK = 3'd3,
		OP_RD_CANCEL = 3'd4,
		OP_WR_CANCEL = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_GRANTED   = 3'd0,
		ST_BUSY      = 3'd1,
		ST_QUEUED    = 3'd2,
		ST_NOT_HELD  = 3'd3,
		ST_FULL      = 3'd4,
		ST_TIMED_OUT = 3'd5
	} status_t;

	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_GRANT  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAKE_W,
		S_WAKE_R
	} state_t;

	// one command per cycle to a wait stack; key is the pushed or searched task
	typedef struct packed {
		logic            push;
		logic            pop;
		logic            remove;
		logic [ID_W-1:0] key;
	} stack_cmd_t;

endpackage
`default_nettype wire

@@ rtl/write_preferring_rw_lock_unit.sv @@
// Write-preferring reader-writer lock.
// Requests enter on in_valid/in_ready (op, task_id, may_wait); results leave on
// out_valid/out_ready (kind, status, granted_task, last). Every request gives one
// status item, followed by grant items for tasks woken from the wait stacks;
// last marks the final item of a request.
// A request is accepted in S_IDLE and its status item is loaded in S_EXEC, then a
// grant item follows per woken task in S_WAKE_W or S_WAKE_R (one writer, or up to
// WAIT_DEPTH readers, popped one a cycle while the output is not stalled, from the
// head cell of the reader stack). No new request is taken until the last item is
// loaded; in_ready returns in the same cycle as that item appears at the output.
// Both wait stacks are rows of cells that shift one place per push, pop or remove; a cancel
// finds the topmost matching entry along the row and closes the gap in the
// same cycle.
// Reset clears the reader count, the writer flags and both fill counts; stack
// cells are not cleared and no sweep is needed.
// A stalled receiver holds the output register; the request in flight waits
// and in_ready stays low until its last item has been loaded and taken room.
`default_nettype none
module write_preferring_rw_lock_unit #(
	parameter int TASK_COUNT   = wprwl_pkg::TASK_COUNT_DEF,
	parameter int WAIT_DEPTH   = wprwl_pkg::WAIT_DEPTH_DEF,
	parameter int READER_LIMIT = wprwl_pkg::READER_LIMIT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [wprwl_pkg::OP_W-1:0]   op,
	input  wire  [wprwl_pkg::ID_W-1:0]   task_id,
	input  wire                          may_wait,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         kind,
	output logic [wprwl_pkg::ST_W-1:0]   status,
	output logic [wprwl_pkg::ID_W-1:0]   granted_task,
	output logic                         last
);

	localparam int FW = $clog2(WAIT_DEPTH + 1);
	localparam int CW = $clog2(READER_LIMIT + 1);
	localparam logic [CW-1:0] LIM    = CW'(READER_LIMIT);
	localparam logic [CW-1:0] LIM_M1 = CW'(READER_LIMIT - 1);
	localparam logic [FW-1:0] DEPTH  = FW'(WAIT_DEPTH);

	wprwl_pkg::state_t state_q, state_nxt;

	logic [wprwl_pkg::OP_W-1:0] op_q;
	logic [wprwl_pkg::ID_W-1:0] task_id_q;
	logic                       may_wait_q;
	logic [wprwl_pkg::ID_W-1:0] wake_id_q;

	logic [CW-1:0] count_q, count_nxt, count_ex;
	logic          holding_q, holding_nxt, holding_ex;
	logic          pending_q, pending_nxt, pending_ex;

	wprwl_pkg::stack_cmd_t r_cmd, w_cmd, r_cmd_ex, w_cmd_ex;
	logic [wprwl_pkg::ID_W-1:0] r_top, w_top;
	logic [FW-1:0]              r_fill, w_fill;
	logic                       r_found, w_found;

	wprwl_pkg::status_t ex_status;
	logic               wake_w, wake_r;

	logic                       out_valid_q;
	wprwl_pkg::kind_t           kind_q, em_kind;
	wprwl_pkg::status_t         status_q, em_status;
	logic [wprwl_pkg::ID_W-1:0] granted_q, em_task;
	logic                       last_q, em_last;
	logic                       emit, slot_free, go;

	assign in_ready  = (state_q == wprwl_pkg::S_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (state_q != wprwl_pkg::S_IDLE);
	assign go        = emit && slot_free;

	wprwl_stack #(.DEPTH(WAIT_DEPTH)) u_rd_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (r_cmd),
		.top    (r_top),
		.fill   (r_fill),
		.found  (r_found)
	);

	wprwl_stack #(.DEPTH(WAIT_DEPTH)) u_wr_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (w_cmd),
		.top    (w_top),
		.fill   (w_fill),
		.found  (w_found)
	);

	// request decision, evaluated in S_EXEC
	always_comb begin
		ex_status  = wprwl_pkg::ST_BUSY;
		wake_w     = 1'b0;
		wake_r     = 1'b0;
		count_ex   = count_q;
		holding_ex = holding_q;
		pending_ex = pending_q;
		r_cmd_ex   = '{push: 1'b0, pop: 1'b0, remove: 1'b0, key: task_id_q};
		w_cmd_ex   = '{push: 1'b0, pop: 1'b0, remove: 1'b0, key: task_id_q};
		if (int'(task_id_q) < TASK_COUNT) begin
			unique case (op_q)
				wprwl_pkg::OP_RD_LOCK: begin
					if (holding_q || pending_q) begin
						if (!may_wait_q) begin
							ex_status = wprwl_pkg::ST_BUSY;
						end else if (r_fill >= DEPTH) begin
							ex_status = wprwl_pkg::ST_FULL;
						end else begin
							r_cmd_ex.push = 1'b1;
							ex_status     = wprwl_pkg::ST_QUEUED;
						end
					end else if (count_q >= LIM) begin
						ex_status = wprwl_pkg::ST_FULL;
					end else begin
						count_ex  = count_q + CW'(1);
						ex_status = wprwl_pkg::ST_GRANTED;
					end
				end
				wprwl_pkg::OP_WR_LOCK: begin
					if (holding_q || (count_q != '0)) begin
						if (!may_wait_q) begin
							ex_status  = wprwl_pkg::ST_BUSY;
							pending_ex = (w_fill != '0);
						end else if (w_fill >= DEPTH) begin
							ex_status  = wprwl_pkg::ST_FULL;
							pending_ex = (w_fill != '0);
						end else begin
							w_cmd_ex.push = 1'b1;
							pending_ex    = 1'b1;
							ex_status     = wprwl_pkg::ST_QUEUED;
						end
					end else begin
						holding_ex = 1'b1;
						pending_ex = 1'b0;
						ex_status  = wprwl_pkg::ST_GRANTED;
					end
				end
				wprwl_pkg::OP_RD_UNLOCK: begin
					if (count_q == '0) begin
						ex_status = wprwl_pkg::ST_NOT_HELD;
					end else begin
						count_ex  = count_q - CW'(1);
						ex_status = wprwl_pkg::ST_GRANTED;
						// last reader out hands over to the top waiting writer
						if ((count_q == CW'(1)) && (w_fill != '0)) begin
							wake_w       = 1'b1;
							w_cmd_ex.pop = 1'b1;
							holding_ex   = 1'b1;
							if (w_fill == FW'(1)) begin
								pending_ex = 1'b0;
							end
						end
					end
				end
				wprwl_pkg::OP_WR_UNLOCK: begin
					if (!holding_q) begin
						ex_status = wprwl_pkg::ST_NOT_HELD;
					end else begin
						holding_ex = 1'b0;
						ex_status  = wprwl_pkg::ST_GRANTED;
						if (w_fill != '0) begin
							wake_w       = 1'b1;
							w_cmd_ex.pop = 1'b1;
							holding_ex   = 1'b1;
							if (w_fill == FW'(1)) begin
								pending_ex = 1'b0;
							end
						end else if ((r_fill != '0) && (count_q < LIM)) begin
							wake_r = 1'b1;
						end
					end
				end
				wprwl_pkg::OP_RD_CANCEL: begin
					r_cmd_ex.remove = 1'b1;
					ex_status = r_found ? wprwl_pkg::ST_TIMED_OUT : wprwl_pkg::ST_NOT_HELD;
				end
				wprwl_pkg::OP_WR_CANCEL: begin
					w_cmd_ex.remove = 1'b1;
					ex_status = w_found ? wprwl_pkg::ST_TIMED_OUT : wprwl_pkg::ST_NOT_HELD;
					if ((w_fill == '0) || ((w_fill == FW'(1)) && w_found)) begin
						pending_ex = 1'b0;
					end
				end
				default: begin
					ex_status = wprwl_pkg::ST_BUSY;
				end
			endcase
		end
	end

	// state updates and stack commands, gated by the output slot
	always_comb begin
		count_nxt   = count_q;
		holding_nxt = holding_q;
		pending_nxt = pending_q;
		r_cmd       = '{push: 1'b0, pop: 1'b0, remove: 1'b0, key: task_id_q};
		w_cmd       = '{push: 1'b0, pop: 1'b0, remove: 1'b0, key: task_id_q};
		if (go && (state_q == wprwl_pkg::S_EXEC)) begin
			count_nxt   = count_ex;
			holding_nxt = holding_ex;
			pending_nxt = pending_ex;
			r_cmd       = r_cmd_ex;
			w_cmd       = w_cmd_ex;
		end else if (go && (state_q == wprwl_pkg::S_WAKE_R)) begin
			count_nxt = count_q + CW'(1);
			r_cmd.pop = 1'b1;
		end
	end

	// item presented to the output register
	always_comb begin
		em_kind   = wprwl_pkg::KIND_STATUS;
		em_status = ex_status;
		em_task   = task_id_q;
		em_last   = !(wake_w || wake_r);
		unique case (state_q)
			wprwl_pkg::S_WAKE_W: begin
				em_kind   = wprwl_pkg::KIND_GRANT;
				em_status = wprwl_pkg::ST_GRANTED;
				em_task   = wake_id_q;
				em_last   = 1'b1;
			end
			wprwl_pkg::S_WAKE_R: begin
				em_kind   = wprwl_pkg::KIND_GRANT;
				em_status = wprwl_pkg::ST_GRANTED;
				em_task   = r_top;
				em_last   = (r_fill == FW'(1)) || (count_q == LIM_M1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			wprwl_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = wprwl_pkg::S_EXEC;
				end
			end
			wprwl_pkg::S_EXEC: begin
				if (slot_free) begin
					if (wake_w) begin
						state_nxt = wprwl_pkg::S_WAKE_W;
					end else if (wake_r) begin
						state_nxt = wprwl_pkg::S_WAKE_R;
					end else begin
						state_nxt = wprwl_pkg::S_IDLE;
					end
				end
			end
			wprwl_pkg::S_WAKE_W: begin
				if (slot_free) begin
					state_nxt = wprwl_pkg::S_IDLE;
				end
			end
			wprwl_pkg::S_WAKE_R: begin
				if (slot_free && em_last) begin
					state_nxt = wprwl_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = wprwl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wprwl_pkg::S_IDLE;
			count_q     <= '0;
			holding_q   <= 1'b0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			count_q   <= count_nxt;
			holding_q <= holding_nxt;
			pending_q <= pending_nxt;
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q       <= op;
			task_id_q  <= task_id;
			may_wait_q <= may_wait;
		end
		if (go && (state_q == wprwl_pkg::S_EXEC)) begin
			wake_id_q <= w_top;
		end
		if (go) begin
			kind_q    <= em_kind;
			status_q  <= em_status;
			granted_q <= em_task;
			last_q    <= em_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign status       = status_q;
	assign granted_task = granted_q;
	assign last         = last_q;

endmodule
`default_nettype wire

@@ rtl/wprwl_cell.sv @@
`default_nettype none
module wprwl_cell (
	input  wire                         clk,
	input  var wprwl_pkg::stack_cmd_t   cmd,
	input  wire                         valid,
	input  wire [wprwl_pkg::ID_W-1:0]   prev_entry,
	input  wire [wprwl_pkg::ID_W-1:0]   next_entry,
	input  wire                         hit_in,
	output logic                        hit_out,
	output logic [wprwl_pkg::ID_W-1:0]  entry
);

	logic [wprwl_pkg::ID_W-1:0] entry_q;

	// hit_out: the topmost copy of the key sits in this cell or above it
	assign hit_out = hit_in | (valid && (entry_q == cmd.key));
	assign entry   = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			entry_q <= prev_entry;
		end else if (cmd.pop || (cmd.remove && hit_out)) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

@@ rtl/wprwl_stack.sv @@
`default_nettype none
module wprwl_stack #(
	parameter int DEPTH = wprwl_pkg::WAIT_DEPTH_DEF,
	localparam int FW = $clog2(DEPTH + 1)
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  var wprwl_pkg::stack_cmd_t   cmd,
	output logic [wprwl_pkg::ID_W-1:0]  top,
	output logic [FW-1:0]               fill,
	output logic                        found
);

	logic [wprwl_pkg::ID_W-1:0] entry [DEPTH];
	logic [DEPTH:0]             hit;
	logic [FW-1:0]              fill_q;

	assign hit[0] = 1'b0;

	// cell 0 is the top; push shifts toward the bottom, pop and remove shift up
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [wprwl_pkg::ID_W-1:0] prev_e;
		logic [wprwl_pkg::ID_W-1:0] next_e;

		if (i == 0) begin : g_first
			assign prev_e = cmd.key;
		end else begin : g_mid
			assign prev_e = entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_e = entry[i];
		end else begin : g_inner
			assign next_e = entry[i+1];
		end

		wprwl_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (FW'(i) < fill_q),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.entry      (entry[i])
		);
	end

	assign top   = entry[0];
	assign fill  = fill_q;
	assign found = hit[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.push) begin
			fill_q <= fill_q + FW'(1);
		end else if (cmd.pop || (cmd.remove && found)) begin
			fill_q <= fill_q - FW'(1);
		end
	end

endmodule
`default_nettype wire

@@ rtl/wprwl_checker.sv @@
`default_nettype none
module wprwl_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_valid,
	input wire                         in_ready,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire                         kind,
	input wire [wprwl_pkg::ST_W-1:0]   status,
	input wire [wprwl_pkg::ID_W-1:0]   granted_task,
	input wire                         last
);

	// a grant to a woken waiter always carries the granted status
	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == wprwl_pkg::KIND_GRANT) |-> (status == wprwl_pkg::ST_GRANTED))
		else $error("grant item with non-granted status");

	// one request at a time: taking an item closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a request is in flight");

	// results appear only while a request is being worked on
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result item appeared with no request in flight");

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status)
			&& $stable(granted_task) && $stable(last))
		else $error("stalled result item changed");

endmodule

bind write_preferring_rw_lock_unit wprwl_checker u_wprwl_checker (.*);
`default_nettype wire

@@ tb/wprwl_lock_checker.sv @@
`timescale 1ns / 1ps
module wprwl_lock_checker
	import wprwl_pkg::*;
#(
	parameter int TASK_COUNT   = TASK_COUNT_DEF,
	parameter int WAIT_DEPTH   = WAIT_DEPTH_DEF,
	parameter int READER_LIMIT = READER_LIMIT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic [OP_W-1:0] op,
	input  logic [ID_W-1:0] task_id,
	input  logic            may_wait,
	input  logic            out_valid,
	input  logic            out_ready,
	input  logic            kind,
	input  logic [ST_W-1:0] status,
	input  logic [ID_W-1:0] granted_task,
	input  logic            last,
	output int              mismatch_count,
	output int              pending_count
);

	localparam int RDQ = 0;
	localparam int WRQ = 1;

	typedef struct packed {
		kind_t           kind;
		status_t         status;
		logic [ID_W-1:0] tid;
		logic            last;
	} lock_reply_t;

	int              readers_in;
	logic            writer_in;
	logic            writer_blocking;
	logic [ID_W-1:0] waiters [2][WAIT_DEPTH];
	int              waiter_fill [2];
	lock_reply_t     step_replies [$];
	lock_reply_t     owed_replies [$];
	int              errs;

	function automatic void note(kind_t k, status_t s, logic [ID_W-1:0] t);
		lock_reply_t r;
		r.kind = k;
		r.status = s;
		r.tid = t;
		r.last = 1'b0;
		step_replies.push_back(r);
	endfunction

	// removes the most recently queued copy of t
	function automatic logic drop_latest(int which, logic [ID_W-1:0] t);
		for (int i = waiter_fill[which] - 1; i >= 0; i--) begin
			if (waiters[which][i] == t) begin
				for (int j = i; j < waiter_fill[which] - 1; j++)
					waiters[which][j] = waiters[which][j + 1];
				waiter_fill[which]--;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [ID_W-1:0] hand_to_writer();
		waiter_fill[WRQ]--;
		writer_in = 1'b1;
		if (waiter_fill[WRQ] == 0) writer_blocking = 1'b0;
		return waiters[WRQ][waiter_fill[WRQ]];
	endfunction

	task automatic predict_request(logic [OP_W-1:0] code, logic [ID_W-1:0] t,
			logic wait_ok);
		logic found;
		lock_reply_t r;
		step_replies.delete();
		if (code > OP_WR_CANCEL || t >= TASK_COUNT) begin
			note(KIND_STATUS, ST_BUSY, t);
		end else begin
			case (code)
				OP_RD_LOCK: begin
					if (writer_in || writer_blocking) begin
						if (!wait_ok) begin
							note(KIND_STATUS, ST_BUSY, t);
						end else if (waiter_fill[RDQ] >= WAIT_DEPTH) begin
							note(KIND_STATUS, ST_FULL, t);
						end else begin
							waiters[RDQ][waiter_fill[RDQ]] = t;
							waiter_fill[RDQ]++;
							note(KIND_STATUS, ST_QUEUED, t);
						end
					end else if (readers_in >= READER_LIMIT) begin
						note(KIND_STATUS, ST_FULL, t);
					end else begin
						readers_in++;
						note(KIND_STATUS, ST_GRANTED, t);
					end
				end
				OP_WR_LOCK: begin
					writer_blocking = 1'b1;
					if (writer_in || readers_in > 0) begin
						if (!wait_ok || waiter_fill[WRQ] >= WAIT_DEPTH) begin
							if (waiter_fill[WRQ] == 0) writer_blocking = 1'b0;
							note(KIND_STATUS, wait_ok ? ST_FULL : ST_BUSY, t);
						end else begin
							waiters[WRQ][waiter_fill[WRQ]] = t;
							waiter_fill[WRQ]++;
							note(KIND_STATUS, ST_QUEUED, t);
						end
					end else begin
						writer_in = 1'b1;
						writer_blocking = 1'b0;
						note(KIND_STATUS, ST_GRANTED, t);
					end
				end
				OP_RD_UNLOCK: begin
					if (readers_in == 0) begin
						note(KIND_STATUS, ST_NOT_HELD, t);
					end else begin
						readers_in--;
						note(KIND_STATUS, ST_GRANTED, t);
						if (readers_in == 0 && waiter_fill[WRQ] > 0)
							note(KIND_GRANT, ST_GRANTED, hand_to_writer());
					end
				end
				OP_WR_UNLOCK: begin
					if (!writer_in) begin
						note(KIND_STATUS, ST_NOT_HELD, t);
					end else begin
						writer_in = 1'b0;
						note(KIND_STATUS, ST_GRANTED, t);
						if (waiter_fill[WRQ] > 0) begin
							note(KIND_GRANT, ST_GRANTED, hand_to_writer());
						end else begin
							while (waiter_fill[RDQ] > 0 && readers_in < READER_LIMIT) begin
								waiter_fill[RDQ]--;
								readers_in++;
								note(KIND_GRANT, ST_GRANTED, waiters[RDQ][waiter_fill[RDQ]]);
							end
						end
					end
				end
				OP_RD_CANCEL: begin
					found = drop_latest(RDQ, t);
					note(KIND_STATUS, found ? ST_TIMED_OUT : ST_NOT_HELD, t);
				end
				default: begin
					found = drop_latest(WRQ, t);
					if (waiter_fill[WRQ] == 0) writer_blocking = 1'b0;
					note(KIND_STATUS, found ? ST_TIMED_OUT : ST_NOT_HELD, t);
				end
			endcase
		end
		foreach (step_replies[i]) begin
			r = step_replies[i];
			r.last = (i == step_replies.size() - 1);
			owed_replies.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lock_reply_t want;
		if (!arst_n) begin
			readers_in = 0;
			writer_in = 1'b0;
			writer_blocking = 1'b0;
			waiter_fill[RDQ] = 0;
			waiter_fill[WRQ] = 0;
			owed_replies.delete();
			errs = 0;
			mismatch_count <= 0;
			pending_count <= 0;
		end else begin
			if (in_valid && in_ready) predict_request(op, task_id, may_wait);
			if (out_valid && out_ready) begin
				if (owed_replies.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: unexpected item: kind %0d status %0d task %0d last %0d",
							$time, kind, status, granted_task, last);
				end else begin
					want = owed_replies.pop_front();
					if (kind !== want.kind || status !== want.status ||
							granted_task !== want.tid || last !== want.last) begin
						errs++;
						if (errs <= 10)
							$display("%0t: mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
								$time, want.kind, want.status, want.tid, want.last,
								kind, status, granted_task, last);
					end
				end
			end
			mismatch_count <= errs;
			pending_count <= owed_replies.size();
		end
	end

endmodule

@@ tb/tb_write_preferring_rw_lock_unit.sv @@
`timescale 1ns / 1ps
module tb_write_preferring_rw_lock_unit;
	import wprwl_pkg::*;

	localparam int CYCLE_LIMIT = 500_000;
	localparam int PHASE_ITEMS = 95;
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic [OP_W-1:0] op = '0;
	logic [ID_W-1:0] task_id = '0;
	logic            may_wait = 1'b0;
	logic            out_ready = 1'b0;
	wire             in_ready;
	wire             out_valid;
	wire             kind;
	wire  [ST_W-1:0] status;
	wire  [ID_W-1:0] granted_task;
	wire             last;
	int              mismatch_count;
	int              pending_count;
	int              tx_idle_pct = 0;
	int              rx_stall_pct = 0;
	int              sent_items = 0;
	int              cycle_count = 0;

	always #6 clk = ~clk;

	write_preferring_rw_lock_unit u_dut (.*);

	wprwl_lock_checker u_checker (.*);

	always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("write_preferring_rw_lock_unit verification failed");
			$finish;
		end
	end

	function automatic logic [ID_W-1:0] pick_tid();
		// half of the ids from a narrow range so that duplicates get queued
		return $urandom_range(1) ? ID_W'($urandom_range(3)) : ID_W'($urandom_range(15));
	endfunction

	task automatic send_request(logic [OP_W-1:0] code, logic [ID_W-1:0] t, logic wait_ok);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		task_id <= t;
		may_wait <= wait_ok;
		do @(posedge clk); while (!in_ready);
		sent_items++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic run_random(int tx_pct, int rx_pct);
		int   stop_at;
		int   k;
		int   mix;
		op_t  main_op;
		op_t  alt_op;
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		stop_at = sent_items + PHASE_ITEMS;
		while (sent_items < stop_at) begin
			mix = $urandom_range(99);
			k = $urandom_range(18, 4);
			if (mix < 4) begin
				settle();
			end else if (mix < 44) begin
				// grab the lock as writer, then pile waiters onto the stacks
				main_op = $urandom_range(1) ? OP_WR_LOCK : OP_RD_LOCK;
				alt_op = (main_op == OP_WR_LOCK) ? OP_RD_LOCK : OP_WR_LOCK;
				send_request(OP_WR_LOCK, pick_tid(), 1'b1);
				repeat (k)
					send_request(($urandom_range(9) < 7) ? main_op : alt_op, pick_tid(),
						1'($urandom_range(9) != 0));
			end else if (mix < 66) begin
				repeat ($urandom_range(20, 1))
					send_request($urandom_range(1) ? OP_WR_UNLOCK : OP_RD_UNLOCK,
						pick_tid(), 1'($urandom_range(1)));
			end else if (mix < 80) begin
				repeat ($urandom_range(6, 1))
					send_request($urandom_range(1) ? OP_RD_CANCEL : OP_WR_CANCEL,
						pick_tid(), 1'($urandom_range(1)));
			end else if (mix < 90) begin
				k = $urandom_range(8, 1);
				repeat (k) send_request(OP_RD_LOCK, pick_tid(), 1'($urandom_range(1)));
				repeat (k) send_request(OP_RD_UNLOCK, pick_tid(), 1'($urandom_range(1)));
			end else begin
				repeat ($urandom_range(6, 1))
					send_request(OP_W'($urandom_range(7)), ID_W'($urandom_range(15)),
						1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 31;
		rx_stall_pct <= 80;
		send_request(OP_RD_UNLOCK, 4'd0, 1'b0);
		send_request(OP_WR_UNLOCK, 4'd15, 1'b1);
		send_request(OP_RD_CANCEL, 4'd5, 1'b0);
		send_request(OP_WR_CANCEL, 4'd5, 1'b1);
		send_request(OP_UNUSED_LO, 4'd15, 1'b1);
		send_request(OP_UNUSED_HI, 4'd0, 1'b0);
		send_request(OP_RD_LOCK, 4'd1, 1'b0);
		send_request(OP_RD_LOCK, 4'd2, 1'b1);
		send_request(OP_WR_LOCK, 4'd3, 1'b0);
		send_request(OP_WR_LOCK, 4'd4, 1'b1);
		send_request(OP_RD_LOCK, 4'd5, 1'b0);
		send_request(OP_RD_LOCK, 4'd6, 1'b1);
		send_request(OP_WR_LOCK, 4'd4, 1'b1);
		send_request(OP_WR_CANCEL, 4'd4, 1'b0);
		send_request(OP_RD_CANCEL, 4'd9, 1'b1);
		send_request(OP_RD_UNLOCK, 4'd1, 1'b0);
		// last reader out hands the lock to the queued writer
		send_request(OP_RD_UNLOCK, 4'd2, 1'b0);
		send_request(OP_RD_LOCK, 4'd7, 1'b1);
		send_request(OP_RD_LOCK, 4'd6, 1'b1);
		send_request(OP_RD_CANCEL, 4'd6, 1'b0);
		send_request(OP_WR_UNLOCK, 4'd4, 1'b0);
		send_request(OP_RD_UNLOCK, 4'd7, 1'b0);
		send_request(OP_RD_UNLOCK, 4'd6, 1'b1);
		send_request(OP_WR_LOCK, 4'd0, 1'b0);
		send_request(OP_WR_LOCK, 4'd15, 1'b1);
		send_request(OP_WR_UNLOCK, 4'd0, 1'b0);
		send_request(OP_WR_UNLOCK, 4'd15, 1'b0);
		settle();

		run_random(31, 80);
		settle();
		run_random(80, 31);
		settle();
		run_random(0, 0);

		settle();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("write_preferring_rw_lock_unit verification clean");
		end else begin
			$display("write_preferring_rw_lock_unit verification failed");
		end
		$finish;
	end

endmodule
